/* hdl/dpsa_pkg.sv */
// ----------------------------------------------------------------------------
// Dipeptide pair score average package
// Item types, constants and the pair score table shared by the block.
// ----------------------------------------------------------------------------
package dpsa_pkg;

	localparam int PAIR_SCORE_W = 7;
	localparam int QUOT_W       = 15;
	localparam int QUOT_CNT_W   = 4;

	localparam logic [7:0]            CHAR_A        = 8'h41;
	localparam logic [7:0]            CHAR_Z        = 8'h5A;
	localparam logic [PAIR_SCORE_W-1:0] SCORE_DEFAULT = 7'd50;
	localparam logic [QUOT_W-1:0]     SCORE_EMPTY   = 15'd12800;
	localparam logic [QUOT_CNT_W-1:0] QUOT_LAST     = 4'd14;

	typedef struct packed {
		logic [7:0] amino_acid;
		logic       is_last;
	} in_item_t;

	typedef struct packed {
		logic [14:0] score_q;
		logic [15:0] pairs_counted;
		logic        overflow;
	} out_item_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= CHAR_A) && (c <= CHAR_Z);
	endfunction

	function automatic logic [PAIR_SCORE_W-1:0] pair_score(input logic [7:0] a,
			input logic [7:0] b);
		logic [PAIR_SCORE_W-1:0] s;
		s = SCORE_DEFAULT;
		case ({a, b})
			"LL": s = 7'd100;
			"AA": s = 7'd96;
			"AL": s = 7'd96;
			"LA": s = 7'd95;
			"LS": s = 7'd89;
			"VL": s = 7'd88;
			"LG": s = 7'd88;
			"EL": s = 7'd87;
			"GL": s = 7'd87;
			"SL": s = 7'd87;
			"LE": s = 7'd87;
			"LV": s = 7'd86;
			"AG": s = 7'd86;
			"VA": s = 7'd85;
			"AV": s = 7'd85;
			"SS": s = 7'd85;
			"GG": s = 7'd84;
			"LK": s = 7'd84;
			"EA": s = 7'd84;
			"EE": s = 7'd84;
			"GA": s = 7'd83;
			"LR": s = 7'd83;
			"AE": s = 7'd83;
			"RL": s = 7'd83;
			"TL": s = 7'd83;
			"DL": s = 7'd83;
			"LD": s = 7'd83;
			"KL": s = 7'd82;
			"IL": s = 7'd82;
			"LT": s = 7'd82;
			"VV": s = 7'd82;
			"LI": s = 7'd82;
			"AS": s = 7'd82;
			"SG": s = 7'd81;
			"GV": s = 7'd81;
			"LP": s = 7'd81;
			"SA": s = 7'd81;
			"IA": s = 7'd81;
			"EK": s = 7'd80;
			"GS": s = 7'd80;
			"VE": s = 7'd80;
			"AI": s = 7'd80;
			"AR": s = 7'd80;
			"EV": s = 7'd79;
			"KA": s = 7'd79;
			"VG": s = 7'd79;
			"VS": s = 7'd79;
			"AK": s = 7'd79;
			"KE": s = 7'd79;
			"DA": s = 7'd79;
			"WW": s = 7'd12;
			"WC": s = 7'd12;
			"CW": s = 7'd12;
			"MW": s = 7'd12;
			"WM": s = 7'd12;
			"CM": s = 7'd12;
			"MC": s = 7'd12;
			"HW": s = 7'd12;
			"WH": s = 7'd12;
			"CC": s = 7'd13;
			"WY": s = 7'd13;
			"YW": s = 7'd13;
			"CH": s = 7'd13;
			"HC": s = 7'd13;
			"WP": s = 7'd14;
			"CY": s = 7'd14;
			default: s = SCORE_DEFAULT;
		endcase
		return s;
	endfunction

endpackage

/* hdl/dpsa_front.sv */
// ----------------------------------------------------------------------------
// Dipeptide pair score front
// Takes one character per item, scores letter pairs and hands each finished
// protein's sum, count and overflow flag to the job queue.
// ----------------------------------------------------------------------------
module dpsa_front import dpsa_pkg::*; #(
	parameter int CNT_W = 16,
	parameter int SUM_W = 23,
	parameter int MAX_PAIRS = 65535
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  in_item_t                   in_data,
	output logic                       push,
	output logic [SUM_W+CNT_W:0]       push_data,
	input  logic                       queue_full
);

	logic [7:0]       prev_char_q;
	logic             prev_present_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic             ovf_q;

	logic             accept;
	logic             pair_ok;
	logic             saturated;
	logic [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0] count_nx;
	logic             ovf_nx;

	assign in_ready  = !queue_full;
	assign accept    = in_valid && in_ready;
	assign pair_ok   = prev_present_q && is_letter(prev_char_q) && is_letter(in_data.amino_acid);
	assign saturated = (count_q == CNT_W'(MAX_PAIRS));

	always_comb begin
		sum_nx   = sum_q;
		count_nx = count_q;
		ovf_nx   = ovf_q;
		if (pair_ok) begin
			if (saturated) begin
				ovf_nx = 1'b1;
			end else begin
				sum_nx   = sum_q + SUM_W'(pair_score(prev_char_q, in_data.amino_acid));
				count_nx = count_q + CNT_W'(1);
			end
		end
	end

	assign push      = accept && in_data.is_last;
	assign push_data = {ovf_nx, count_nx, sum_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_char_q    <= '0;
			prev_present_q <= 1'b0;
			sum_q          <= '0;
			count_q        <= '0;
			ovf_q          <= 1'b0;
		end else if (accept) begin
			if (in_data.is_last) begin
				prev_char_q    <= '0;
				prev_present_q <= 1'b0;
				sum_q          <= '0;
				count_q        <= '0;
				ovf_q          <= 1'b0;
			end else begin
				prev_char_q    <= in_data.amino_acid;
				prev_present_q <= 1'b1;
				sum_q          <= sum_nx;
				count_q        <= count_nx;
				ovf_q          <= ovf_nx;
			end
		end
	end

endmodule

/* hdl/dpsa_queue.sv */
// ----------------------------------------------------------------------------
// Dipeptide pair score job queue
// Two-entry queue between the front and the divider.
// ----------------------------------------------------------------------------
module dpsa_queue #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             full,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       fill_q;

	assign full     = (fill_q == 2'd2);
	assign empty    = (fill_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* hdl/dpsa_back.sv */
// ----------------------------------------------------------------------------
// Dipeptide pair score back
// Takes a finished protein from the queue, divides sum times 256 by the pair
// count one quotient bit per cycle and presents the result item.
// ----------------------------------------------------------------------------
module dpsa_back import dpsa_pkg::*; #(
	parameter int CNT_W = 16,
	parameter int SUM_W = 23
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 queue_empty,
	input  logic [SUM_W+CNT_W:0] pop_data,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data
);

	div_state_t state_q, state_nx;

	logic [SUM_W-1:0]      job_sum;
	logic [CNT_W-1:0]      job_count;
	logic                  job_ovf;
	logic [SUM_W+7:0]      dividend;

	logic [CNT_W-1:0]      rem_q;
	logic [CNT_W-1:0]      div_q;
	logic [QUOT_W-1:0]     lo_q;
	logic [QUOT_W-1:0]     quot_q;
	logic [QUOT_CNT_W-1:0] step_q;
	logic [CNT_W-1:0]      pairs_q;
	logic                  ovf_q;

	logic [CNT_W:0]        trial;
	logic                  qbit;
	logic [CNT_W:0]        diff;

	logic                  load;
	logic                  slot_free;
	logic                  deliver;
	logic                  out_valid_q;
	out_item_t             out_q;

	assign {job_ovf, job_count, job_sum} = pop_data;
	assign dividend  = {job_sum, 8'd0};

	assign trial     = {rem_q, lo_q[QUOT_W-1]};
	assign qbit      = (trial >= {1'b0, div_q});
	assign diff      = trial - {1'b0, div_q};

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		load     = 1'b0;
		deliver  = 1'b0;
		unique case (state_q)
			DIV_IDLE: begin
				if (!queue_empty) begin
					load     = 1'b1;
					state_nx = (job_count == '0) ? DIV_DONE : DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (step_q == QUOT_LAST) begin
					state_nx = DIV_DONE;
				end
			end
			DIV_DONE: begin
				if (slot_free) begin
					deliver  = 1'b1;
					state_nx = DIV_IDLE;
				end
			end
			default: state_nx = DIV_IDLE;
		endcase
	end

	assign pop = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= DIV_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q   <= dividend[SUM_W+7:QUOT_W];
			lo_q    <= dividend[QUOT_W-1:0];
			div_q   <= job_count;
			pairs_q <= job_count;
			ovf_q   <= job_ovf;
			step_q  <= '0;
			quot_q  <= (job_count == '0) ? SCORE_EMPTY : '0;
		end else if (state_q == DIV_RUN) begin
			rem_q  <= qbit ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			lo_q   <= {lo_q[QUOT_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], qbit};
			step_q <= step_q + QUOT_CNT_W'(1);
		end
		if (deliver) begin
			out_q.score_q       <= quot_q;
			out_q.pairs_counted <= 16'(pairs_q);
			out_q.overflow      <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/dipeptide_pair_score_average.sv */
// ----------------------------------------------------------------------------
// Dipeptide pair score average
// Scores neighbouring letter pairs of a protein and reports the mean score.
// ----------------------------------------------------------------------------
// Channel  Handshake             Payload     Item
// in       in_valid / in_ready   in_data     one character, is_last on the end
// out      out_valid / out_ready out_data    mean score, pair count, overflow
//
// The front takes one character per cycle while the job queue has room.
// A protein with at least one pair is divided in the back in these steps: load,
// 15 quotient bits from the shared subtractor, and hand-over to the output
// register. A protein with no pair is only loaded and handed over.
// The queue holds two finished proteins, so the front stalls only when
// proteins shorter than the divider time arrive in a row or the output is
// held off.
// Reset clears the running sums, the queue and the output valid.
// ----------------------------------------------------------------------------
module dipeptide_pair_score_average import dpsa_pkg::*; #(
	parameter int MAX_PAIRS = 65535
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data
);

	localparam int CNT_W = $clog2(MAX_PAIRS + 1);
	localparam int SUM_W = CNT_W + PAIR_SCORE_W;
	localparam int JOB_W = SUM_W + CNT_W + 1;

	logic             push;
	logic [JOB_W-1:0] push_data;
	logic             pop;
	logic [JOB_W-1:0] pop_data;
	logic             queue_full;
	logic             queue_empty;

	dpsa_front #(
		.CNT_W     (CNT_W),
		.SUM_W     (SUM_W),
		.MAX_PAIRS (MAX_PAIRS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	dpsa_queue #(
		.WIDTH (JOB_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (queue_full),
		.empty     (queue_empty)
	);

	dpsa_back #(
		.CNT_W (CNT_W),
		.SUM_W (SUM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop_data    (pop_data),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule
